### design/timed_event_scheduler_core_macros.svh
// ----------------------------------------------------------------------------
// timed event scheduler assertion macros
// shared property wrappers, clocked on clk and gated by rst_n
// ----------------------------------------------------------------------------
`ifndef TIMED_EVENT_SCHEDULER_CORE_MACROS_SVH
`define TIMED_EVENT_SCHEDULER_CORE_MACROS_SVH

// same-cycle implication
`define TES_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/tes_pkg.sv
// ----------------------------------------------------------------------------
// tes_pkg
// shared types and constants of the timed event scheduler
// ----------------------------------------------------------------------------
package tes_pkg;

  localparam int DUE_W       = 64;
  localparam int OFFSET_W    = 32;
  localparam int TAG_FIELD_W = 16;

  typedef enum logic [1:0] {
    CMD_BOOT  = 2'd0,
    CMD_HALT  = 2'd1,
    CMD_SCHED = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_e_t;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_FULL   = 2'd1,
    STS_HALTED = 2'd2
  } status_e_t;

  typedef enum logic {
    SQ_IDLE  = 1'b0,
    SQ_DRAIN = 1'b1
  } seq_state_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic pop;
  } cell_ctrl_t;

endpackage

### design/tes_if.sv
// ----------------------------------------------------------------------------
// tes_in_if / tes_out_if
// valid/ready channels of the scheduler: command beats in, result beats out
// ----------------------------------------------------------------------------
interface tes_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] sample_offset;
  logic [15:0] event_tag;

  modport source (output valid, command, sample_offset, event_tag, input ready);
  modport sink   (input valid, command, sample_offset, event_tag, output ready);
endinterface

interface tes_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        fired;
  logic [15:0] fired_tag;
  logic        last;

  modport source (output valid, status, fired, fired_tag, last, input ready);
  modport sink   (input valid, status, fired, fired_tag, last, output ready);
endinterface

### design/tes_cell.sv
// ----------------------------------------------------------------------------
// tes_cell
// one slot of the sorted queue: holds a due time and a tag, shifts right on
// insert and left on pop
// ----------------------------------------------------------------------------
module tes_cell
  import tes_pkg::*;
#(
  parameter int TAG_W = 16
) (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [DUE_W-1:0] new_due,
  input  logic [TAG_W-1:0] new_tag,
  input  logic             occ,
  input  logic             at_tail,
  input  logic             prev_gt,
  input  logic [DUE_W-1:0] prev_due,
  input  logic [TAG_W-1:0] prev_tag,
  input  logic [DUE_W-1:0] next_due,
  input  logic [TAG_W-1:0] next_tag,
  output logic [DUE_W-1:0] due_r,
  output logic [TAG_W-1:0] tag_r,
  output logic             gt
);

  logic [DUE_W-1:0] due_nxt;
  logic [TAG_W-1:0] tag_nxt;

  // entries due later than the new one move aside; equal ones stay ahead
  assign gt = occ && (due_r > new_due);

  always_comb begin
    due_nxt = due_r;
    tag_nxt = tag_r;
    if (ctrl.insert) begin
      if (prev_gt) begin
        due_nxt = prev_due;
        tag_nxt = prev_tag;
      end else if (gt || at_tail) begin
        due_nxt = new_due;
        tag_nxt = new_tag;
      end
    end else if (ctrl.pop) begin
      due_nxt = next_due;
      tag_nxt = next_tag;
    end
  end

  always_ff @(posedge clk) begin
    due_r <= due_nxt;
    tag_r <= tag_nxt;
  end

endmodule

### design/timed_event_scheduler_core.sv
// ----------------------------------------------------------------------------
// timed_event_scheduler_core
// sample-clocked event scheduler built as a sorted shift-register queue
// ----------------------------------------------------------------------------
//  channel   dir  beat contents
//  in_chan   in   command, sample_offset, event_tag
//  out_chan  out  status, fired, fired_tag, last
//
//  boot, halt and schedule each give one result beat
//  a running tick gives no beat on accept, then one beat per fired tag, or
//  one when nothing is due; while out_chan takes beats, the row of cells
//  pops its head once per cycle; insertion compare-and-shifts the whole row
//  reset is synchronous; no clearing pass, queue slots are tracked by count
//  a stalled result beat holds the block until out_chan takes it
// ----------------------------------------------------------------------------
`include "timed_event_scheduler_core_macros.svh"

module timed_event_scheduler_core
  import tes_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64,
  parameter int TAG_BITS    = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  tes_in_if.sink    in_chan,
  tes_out_if.source out_chan
);

  localparam int TAG_W = (TAG_BITS < TAG_FIELD_W) ? TAG_BITS : TAG_FIELD_W;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // control state
  seq_state_t         state_r, state_nxt;
  logic               running_r, running_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [DUE_W-1:0]   clock_r, clock_nxt;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic               out_fired_r, out_fired_nxt;
  logic [TAG_W-1:0]   out_tag_r, out_tag_nxt;
  logic               out_last_r, out_last_nxt;

  // cell row
  cell_ctrl_t         ctrl;
  logic [DUE_W-1:0]   new_due;
  logic [TAG_W-1:0]   new_tag;
  logic [DUE_W-1:0]   c_due [QUEUE_DEPTH];
  logic [TAG_W-1:0]   c_tag [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] c_gt;
  logic [QUEUE_DEPTH-1:0] c_occ;
  logic [QUEUE_DEPTH-1:0] c_tail;

  logic               in_fire;
  logic               slot_free;
  logic               drain_go;
  logic               head_due;
  logic               next_due;
  logic               pop_go;
  logic               tick_end;
  logic               q_full;

  // handshake
  assign slot_free     = !out_valid_r || out_chan.ready;
  assign in_chan.ready = (state_r == SQ_IDLE) && slot_free;
  assign in_fire       = in_chan.valid && in_chan.ready;

  assign out_chan.valid     = out_valid_r;
  assign out_chan.status    = out_status_r;
  assign out_chan.fired     = out_fired_r;
  assign out_chan.fired_tag = TAG_FIELD_W'(out_tag_r);
  assign out_chan.last      = out_last_r;

  // new entry due at clock plus offset, wraps mod 2^64
  assign new_due = clock_r + DUE_W'(in_chan.sample_offset);
  assign new_tag = in_chan.event_tag[TAG_W-1:0];
  assign q_full  = (count_r == CNT_W'(QUEUE_DEPTH));

  // the row stays sorted, so due entries form a prefix and the head is next
  assign head_due = c_occ[0] && (c_due[0] <= clock_r);
  assign next_due = c_occ[1] && (c_due[1] <= clock_r);
  assign drain_go = (state_r == SQ_DRAIN) && slot_free;
  assign pop_go   = drain_go && head_due;
  assign tick_end = drain_go && (!head_due || !next_due);

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      logic             p_gt;
      logic [DUE_W-1:0] p_due;
      logic [TAG_W-1:0] p_tag;
      logic [DUE_W-1:0] n_due;
      logic [TAG_W-1:0] n_tag;

      assign c_occ[gi]  = CNT_W'(gi) < count_r;
      assign c_tail[gi] = CNT_W'(gi) == count_r;

      if (gi == 0) begin : g_first
        assign p_gt  = 1'b0;
        assign p_due = new_due;
        assign p_tag = new_tag;
      end else begin : g_mid
        assign p_gt  = c_gt[gi-1];
        assign p_due = c_due[gi-1];
        assign p_tag = c_tag[gi-1];
      end

      if (gi == QUEUE_DEPTH - 1) begin : g_last
        assign n_due = c_due[gi];
        assign n_tag = c_tag[gi];
      end else begin : g_inner
        assign n_due = c_due[gi+1];
        assign n_tag = c_tag[gi+1];
      end

      tes_cell #(
        .TAG_W (TAG_W)
      ) u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .new_due  (new_due),
        .new_tag  (new_tag),
        .occ      (c_occ[gi]),
        .at_tail  (c_tail[gi]),
        .prev_gt  (p_gt),
        .prev_due (p_due),
        .prev_tag (p_tag),
        .next_due (n_due),
        .next_tag (n_tag),
        .due_r    (c_due[gi]),
        .tag_r    (c_tag[gi]),
        .gt       (c_gt[gi])
      );
    end
  endgenerate

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SQ_IDLE: begin
        if (in_fire && (cmd_e_t'(in_chan.command) == CMD_TICK) && running_r) begin
          state_nxt = SQ_DRAIN;
        end
      end
      SQ_DRAIN: begin
        if (tick_end) begin
          state_nxt = SQ_IDLE;
        end
      end
      default: state_nxt = SQ_IDLE;
    endcase
  end

  // sequencer outputs and datapath updates
  always_comb begin
    ctrl           = '0;
    running_nxt    = running_r;
    count_nxt      = count_r;
    clock_nxt      = clock_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_status_nxt = out_status_r;
    out_fired_nxt  = out_fired_r;
    out_tag_nxt    = out_tag_r;
    out_last_nxt   = out_last_r;
    unique case (state_r)
      SQ_IDLE: begin
        if (in_fire) begin
          out_status_nxt = STS_OK;
          out_fired_nxt  = 1'b0;
          out_tag_nxt    = '0;
          out_last_nxt   = 1'b1;
          out_valid_nxt  = 1'b1;
          unique case (cmd_e_t'(in_chan.command))
            CMD_BOOT: begin
              running_nxt = 1'b1;
              count_nxt   = '0;
              clock_nxt   = '0;
            end
            CMD_HALT: begin
              running_nxt = 1'b0;
            end
            CMD_SCHED: begin
              if (!running_r) begin
                out_status_nxt = STS_HALTED;
              end else if (q_full) begin
                out_status_nxt = STS_FULL;
              end else begin
                ctrl.insert = 1'b1;
                count_nxt   = count_r + CNT_W'(1);
              end
            end
            CMD_TICK: begin
              // running ticks produce their beats while draining
              if (!running_r) begin
                out_status_nxt = STS_HALTED;
              end else begin
                out_valid_nxt = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      SQ_DRAIN: begin
        if (drain_go) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STS_OK;
          out_fired_nxt  = head_due;
          out_tag_nxt    = head_due ? c_tag[0] : '0;
          out_last_nxt   = !head_due || !next_due;
          if (pop_go) begin
            ctrl.pop  = 1'b1;
            count_nxt = count_r - CNT_W'(1);
          end
          if (tick_end) begin
            clock_nxt = clock_r + DUE_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SQ_IDLE;
      running_r   <= 1'b0;
      count_r     <= '0;
      clock_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      running_r   <= running_nxt;
      count_r     <= count_nxt;
      clock_r     <= clock_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_fired_r  <= out_fired_nxt;
    out_tag_r    <= out_tag_nxt;
    out_last_r   <= out_last_nxt;
  end

  // checks
  `TES_ASSERT_NOW(a_count_range, 1'b1, count_r <= CNT_W'(QUEUE_DEPTH), "queue count overflow")
  `TES_ASSERT_NOW(a_head_sorted, count_r > CNT_W'(1), c_due[0] <= c_due[1], "queue head unsorted")
  `TES_ASSERT_NEXT(a_pop_count, pop_go, count_r == $past(count_r) - CNT_W'(1), "pop count slip")
  `TES_ASSERT_NOW(a_fired_ok, out_valid_r && out_fired_r, out_status_r == STS_OK, "fired with bad status")
  `TES_ASSERT_NEXT(a_drain_clock, tick_end, clock_r == $past(clock_r) + DUE_W'(1), "clock not advanced")

endmodule
